FILE: rtl/matrix_multiply_engine_defines.svh
// Assertion macros shared by the matrix multiply engine sources.
`ifndef MATRIX_MULTIPLY_ENGINE_DEFINES_SVH
`define MATRIX_MULTIPLY_ENGINE_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define MME_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define MME_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define MME_ASSERT(lbl, prop, msg)
`define MME_ASSERT_RST(lbl, prop, msg)
`endif

`endif

FILE: rtl/mme_pkg.sv
package mme_pkg;

  localparam int MAX_DIM_DEF    = 8;
  localparam int ELEM_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF  = 16;

  localparam int IO_ELEM_W = 32;
  localparam int IDX_W     = 3;
  localparam int DIM_W     = 4;
  localparam int CFG_IDX_W = 2;

  localparam logic [DIM_W-1:0] DIM_RESET = 4'd8;

  localparam logic [1:0] OP_LOAD_A  = 2'd0;
  localparam logic [1:0] OP_LOAD_B  = 2'd1;
  localparam logic [1:0] OP_COMPUTE = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_ROWS_A     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INNER_SIZE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS_B     = 2'd2;

  typedef struct packed {
    logic             valid;
    logic             first;
    logic             last_k;
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
    logic             last;
  } mme_tag_t;

endpackage

FILE: rtl/mme_mac.sv
`include "matrix_multiply_engine_defines.svh"

module mme_mac #(
  parameter int MAX_DIM    = mme_pkg::MAX_DIM_DEF,
  parameter int ELEM_WIDTH = mme_pkg::ELEM_WIDTH_DEF,
  parameter int FRAC_BITS  = mme_pkg::FRAC_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         advance,
  input  mme_pkg::mme_tag_t            tag_in,
  input  logic signed [ELEM_WIDTH-1:0] a_data,
  input  logic signed [ELEM_WIDTH-1:0] b_data,
  output logic                         res_valid,
  output mme_pkg::mme_tag_t            res_tag,
  output logic signed [ELEM_WIDTH-1:0] res_value,
  output logic                         res_sat
);

  localparam int PROD_W = 2 * ELEM_WIDTH;
  localparam int ACC_W  = PROD_W + $clog2(MAX_DIM) + 1;
  localparam int TOP_W  = ACC_W - ELEM_WIDTH + 1;

  localparam logic signed [ELEM_WIDTH-1:0] ELEM_MAX = {1'b0, {(ELEM_WIDTH - 1){1'b1}}};
  localparam logic signed [ELEM_WIDTH-1:0] ELEM_MIN = {1'b1, {(ELEM_WIDTH - 1){1'b0}}};

  mme_pkg::mme_tag_t        p_tag;
  mme_pkg::mme_tag_t        a_tag;
  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  acc;
  logic signed [ACC_W-1:0]  shifted;
  logic [TOP_W-1:0]         top_bits;
  logic                     in_range;

  always_ff @(posedge clk) begin
    if (rst) begin
      p_tag <= '0;
      a_tag <= '0;
    end else if (advance) begin
      p_tag <= tag_in;
      prod  <= a_data * b_data;
      a_tag <= p_tag;
      if (p_tag.valid) begin
        if (p_tag.first) begin
          acc <= ACC_W'(prod);
        end else begin
          acc <= acc + ACC_W'(prod);
        end
      end
    end
  end

  always_comb begin
    shifted  = acc >>> FRAC_BITS;
    top_bits = shifted[ACC_W-1:ELEM_WIDTH-1];
    in_range = (&top_bits) || !(|top_bits);
    if (in_range) begin
      res_value = shifted[ELEM_WIDTH-1:0];
    end else if (shifted[ACC_W-1]) begin
      res_value = ELEM_MIN;
    end else begin
      res_value = ELEM_MAX;
    end
    res_sat   = !in_range;
    res_valid = a_tag.valid && a_tag.last_k;
    res_tag   = a_tag;
  end

  `MME_ASSERT(a_continue_sum,
    p_tag.valid && !p_tag.first |-> a_tag.valid && !a_tag.last_k &&
      a_tag.row == p_tag.row && a_tag.col == p_tag.col,
    "A partial product arrived without the running sum of its element.")
  `MME_ASSERT(a_fresh_sum,
    p_tag.valid && p_tag.first && a_tag.valid |-> a_tag.last_k,
    "A new sum started before the previous one was finished.")
  `MME_ASSERT_RST(a_reset_empty,
    rst |=> !p_tag.valid && !a_tag.valid,
    "The accumulator pipeline holds work after reset.")

endmodule

FILE: rtl/matrix_multiply_engine.sv
// Fixed-point matrix multiplier. Op 0 and op 1 write one element of A or B into
// on-chip memories; loads outside the configured size are dropped. Op 2 walks
// C = A * B in row-major order and returns one result transfer per element of C,
// the last one flagged. The walk reads one A and one B element per cycle, while
// the output is not stalled, from the single read port of each memory, so a
// compute item holds the input side until all of its products are issued. The
// products pass the read and tag registers, the product and accumulator
// registers and the output register. A stalled output freezes the walk. Sums
// are exact, shifted right by FRAC_BITS and saturated to ELEM_WIDTH bits with a
// flag. Elements must be loaded before a product reads them. Configuration
// writes are taken every cycle.
`include "matrix_multiply_engine_defines.svh"

module matrix_multiply_engine #(
  parameter int MAX_DIM    = mme_pkg::MAX_DIM_DEF,
  parameter int ELEM_WIDTH = mme_pkg::ELEM_WIDTH_DEF,
  parameter int FRAC_BITS  = mme_pkg::FRAC_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [1:0]                           op,
  input  logic [mme_pkg::IDX_W-1:0]            row_index,
  input  logic [mme_pkg::IDX_W-1:0]            col_index,
  input  logic signed [mme_pkg::IO_ELEM_W-1:0] element_value,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [mme_pkg::IDX_W-1:0]            out_row,
  output logic [mme_pkg::IDX_W-1:0]            out_col,
  output logic signed [mme_pkg::IO_ELEM_W-1:0] out_value,
  output logic                                 saturated,
  output logic                                 last,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [mme_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [mme_pkg::DIM_W-1:0]            cfg_data
);

  localparam int DEPTH  = MAX_DIM * MAX_DIM;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int DIM_W  = mme_pkg::DIM_W;
  localparam int IDX_W  = mme_pkg::IDX_W;

  function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] d;
    if (v == '0) begin
      d = DIM_W'(1);
    end else if (int'(v) > MAX_DIM) begin
      d = DIM_W'(MAX_DIM);
    end else begin
      d = v;
    end
    return d;
  endfunction

  logic [DIM_W-1:0] rows_a;
  logic [DIM_W-1:0] inner_size;
  logic [DIM_W-1:0] cols_b;
  logic [DIM_W-1:0] nr;
  logic [DIM_W-1:0] nk;
  logic [DIM_W-1:0] nc;

  logic [ELEM_WIDTH-1:0] a_mem [DEPTH];
  logic [ELEM_WIDTH-1:0] b_mem [DEPTH];
  logic signed [ELEM_WIDTH-1:0] a_rd;
  logic signed [ELEM_WIDTH-1:0] b_rd;

  logic             issuing;
  logic [CNT_W-1:0] r;
  logic [CNT_W-1:0] c;
  logic [CNT_W-1:0] k;
  logic             k_end;
  logic             c_end;
  logic             r_end;
  logic             advance;
  logic             in_xfer;
  logic             a_wr_ok;
  logic             b_wr_ok;
  logic [ADDR_W-1:0] w_addr;
  logic [ADDR_W-1:0] a_raddr;
  logic [ADDR_W-1:0] b_raddr;

  mme_pkg::mme_tag_t s_tag;
  mme_pkg::mme_tag_t res_tag;
  logic              res_valid;
  logic signed [ELEM_WIDTH-1:0] res_value;
  logic              res_sat;

  assign cfg_ready = 1'b1;
  assign in_ready  = !issuing;
  assign in_xfer   = in_valid && in_ready;
  assign advance   = !out_valid || out_ready;

  assign nr = eff_dim(rows_a);
  assign nk = eff_dim(inner_size);
  assign nc = eff_dim(cols_b);

  assign k_end = DIM_W'(k) == nk - DIM_W'(1);
  assign c_end = DIM_W'(c) == nc - DIM_W'(1);
  assign r_end = DIM_W'(r) == nr - DIM_W'(1);

  assign w_addr  = ADDR_W'(int'(row_index) * MAX_DIM + int'(col_index));
  assign a_raddr = ADDR_W'(int'(r) * MAX_DIM + int'(k));
  assign b_raddr = ADDR_W'(int'(k) * MAX_DIM + int'(c));
  assign a_wr_ok = in_xfer && op == mme_pkg::OP_LOAD_A &&
                   DIM_W'(row_index) < nr && DIM_W'(col_index) < nk;
  assign b_wr_ok = in_xfer && op == mme_pkg::OP_LOAD_B &&
                   DIM_W'(row_index) < nk && DIM_W'(col_index) < nc;

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_a     <= mme_pkg::DIM_RESET;
      inner_size <= mme_pkg::DIM_RESET;
      cols_b     <= mme_pkg::DIM_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        mme_pkg::CFG_ROWS_A:     rows_a     <= cfg_data;
        mme_pkg::CFG_INNER_SIZE: inner_size <= cfg_data;
        mme_pkg::CFG_COLS_B:     cols_b     <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (a_wr_ok) begin
      a_mem[w_addr] <= element_value[ELEM_WIDTH-1:0];
    end
    if (advance && issuing) begin
      a_rd <= a_mem[a_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (b_wr_ok) begin
      b_mem[w_addr] <= element_value[ELEM_WIDTH-1:0];
    end
    if (advance && issuing) begin
      b_rd <= b_mem[b_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      issuing <= 1'b0;
      r       <= '0;
      c       <= '0;
      k       <= '0;
    end else if (!issuing) begin
      if (in_xfer && op == mme_pkg::OP_COMPUTE) begin
        issuing <= 1'b1;
        r       <= '0;
        c       <= '0;
        k       <= '0;
      end
    end else if (advance) begin
      if (!k_end) begin
        k <= k + 1'b1;
      end else begin
        k <= '0;
        if (!c_end) begin
          c <= c + 1'b1;
        end else begin
          c <= '0;
          if (!r_end) begin
            r <= r + 1'b1;
          end else begin
            issuing <= 1'b0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s_tag <= '0;
    end else if (advance) begin
      s_tag.valid  <= issuing;
      s_tag.first  <= k == '0;
      s_tag.last_k <= k_end;
      s_tag.row    <= IDX_W'(r);
      s_tag.col    <= IDX_W'(c);
      s_tag.last   <= r_end && c_end;
    end
  end

  mme_mac #(
    .MAX_DIM    (MAX_DIM),
    .ELEM_WIDTH (ELEM_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_mac (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .tag_in    (s_tag),
    .a_data    (a_rd),
    .b_data    (b_rd),
    .res_valid (res_valid),
    .res_tag   (res_tag),
    .res_value (res_value),
    .res_sat   (res_sat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= res_valid;
      if (res_valid) begin
        out_row   <= res_tag.row;
        out_col   <= res_tag.col;
        out_value <= mme_pkg::IO_ELEM_W'(res_value);
        saturated <= res_sat;
        last      <= res_tag.last;
      end
    end
  end

  `MME_ASSERT(a_compute_busy,
    in_valid && in_ready && op == mme_pkg::OP_COMPUTE |=> !in_ready,
    "A compute transfer did not start the product walk.")
  `MME_ASSERT(a_walk_holds,
    issuing && !advance |=> $stable(r) && $stable(c) && $stable(k),
    "The product walk moved while the output was stalled.")
  `MME_ASSERT_RST(a_reset_idle,
    rst |=> !out_valid && in_ready,
    "The engine is not idle after reset.")

endmodule
